// ===== sv/cph_pkg.sv =====
// Shared types and constants for the convex polygon hit test.
package cph_pkg;

   localparam int MAX_VERTICES_DEF = 64;
   localparam int COORD_BITS_DEF = 16;

   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_APPEND = 2'd1;
   localparam logic [1:0] ACT_TEST = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic valid;
      logic outside;
      logic prod_valid;
   } tok_flags_type;

endpackage

// ===== sv/cph_if.sv =====
// Request and response channel interfaces for the convex polygon hit test.
interface cph_req_if #(
   parameter int COORD_BITS = cph_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic [1:0]                   action;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;

   modport source (output valid, action, point_x, point_y, input ready);
   modport sink (input valid, action, point_x, point_y, output ready);
endinterface

interface cph_rsp_if #(
   parameter int COORD_BITS = cph_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic                         inside_res;
   logic                         store_full;
   logic signed [COORD_BITS-1:0] mid_x;
   logic signed [COORD_BITS-1:0] mid_y;
   logic [COORD_BITS-1:0]        span_x;
   logic [COORD_BITS-1:0]        span_y;

   modport source (output valid, inside_res, store_full, mid_x, mid_y, span_x, span_y,
                   input ready);
   modport sink (input valid, inside_res, store_full, mid_x, mid_y, span_x, span_y,
                 output ready);
endinterface

// ===== sv/convex_polygon_hit_test.sv =====
// Top level of the convex polygon hit test: vertex cell chain, bounding box and result stage.
//
//   Channel   Direction   Handshake          Payload
//   req_if    in          valid / ready      action, point_x, point_y
//   rsp_if    out         valid / ready      inside_res, store_full, mid_x, mid_y, span_x, span_y
//
// The block works on one item at a time. A clear, an append or an unused action passes
// through the finish state into the output register; a test first passes the point once
// through the chain of MAX_VERTICES vertex cells, then the finish state and the output register.
// Reset clears the vertex count and the bounding box; vertex cells are never cleared.
// A result that is not taken waits in the output register, with one holding entry behind it.
module convex_polygon_hit_test #(
   parameter int MAX_VERTICES = cph_pkg::MAX_VERTICES_DEF,
   parameter int COORD_BITS = cph_pkg::COORD_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   cph_req_if.sink   req_if,
   cph_rsp_if.source rsp_if
);
   import cph_pkg::*;

   localparam int COUNT_BITS = $clog2(MAX_VERTICES + 1);
   localparam int PROD_BITS = 2 * COORD_BITS + 2;
   localparam int RES_BITS = 2 + 4 * COORD_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_FULL = COUNT_BITS'(MAX_VERTICES);

   state_type                    state_ff, state_in;
   logic [COUNT_BITS-1:0]        count_ff, count_in;
   logic signed [COORD_BITS-1:0] min_x_ff, min_x_in, max_x_ff, max_x_in;
   logic signed [COORD_BITS-1:0] min_y_ff, min_y_in, max_y_ff, max_y_in;
   logic                         inside_ff, inside_in, full_ff, full_in;
   logic                         launch_ff, launch_in;
   logic signed [COORD_BITS-1:0] launch_x_ff, launch_y_ff;

   logic                         accept, req_ready, finish, chain_done, outside_fin, vert_we;

   logic signed [COORD_BITS-1:0] vx [MAX_VERTICES];
   logic signed [COORD_BITS-1:0] vy [MAX_VERTICES];
   tok_flags_type                tok_flags [MAX_VERTICES+1];
   logic signed [COORD_BITS-1:0] tok_x [MAX_VERTICES+1];
   logic signed [COORD_BITS-1:0] tok_y [MAX_VERTICES+1];
   logic signed [PROD_BITS-1:0]  tok_prod_a [MAX_VERTICES+1];
   logic signed [PROD_BITS-1:0]  tok_prod_b [MAX_VERTICES+1];

   logic [COORD_BITS:0]          sum_x, sum_y;
   logic [COORD_BITS-1:0]        span_x, span_y;
   logic [RES_BITS-1:0]          res_data;

   logic                         rsp_valid_ff, rsp_valid_in, pend_valid_ff, pend_valid_in;
   logic [RES_BITS-1:0]          rsp_data_ff, pend_data_ff;
   logic                         out_free, load_out_pend, load_out_res, load_pend;

   assign accept = req_if.valid & req_ready;
   assign req_if.ready = req_ready;

   // Sequencer: next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_if.action == ACT_TEST) ? ST_RUN : ST_FINISH;
            end
         end
         ST_RUN: begin
            if (chain_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer: outputs.
   always_comb begin
      req_ready = (state_ff == ST_IDLE) & ~pend_valid_ff;
      finish = state_ff == ST_FINISH;
      chain_done = (state_ff == ST_RUN) & tok_flags[MAX_VERTICES].valid;
      launch_in = accept & (req_if.action == ACT_TEST);
   end

   assign vert_we = accept & (req_if.action == ACT_APPEND) & (count_ff != COUNT_FULL);
   assign outside_fin = tok_flags[MAX_VERTICES].outside |
                        (tok_flags[MAX_VERTICES].prod_valid &
                         (tok_prod_a[MAX_VERTICES] > tok_prod_b[MAX_VERTICES]));

   // Vertex count, bounding box and result flags.
   always_comb begin
      count_in = count_ff;
      min_x_in = min_x_ff;
      max_x_in = max_x_ff;
      min_y_in = min_y_ff;
      max_y_in = max_y_ff;
      inside_in = inside_ff;
      full_in = full_ff;
      if (accept) begin
         inside_in = 1'b0;
         full_in = 1'b0;
         case (req_if.action)
            ACT_CLEAR: begin
               count_in = '0;
               min_x_in = '0;
               max_x_in = '0;
               min_y_in = '0;
               max_y_in = '0;
            end
            ACT_APPEND: begin
               if (count_ff == COUNT_FULL) begin
                  full_in = 1'b1;
               end else begin
                  count_in = count_ff + COUNT_BITS'(1);
                  if (count_ff == '0) begin
                     min_x_in = req_if.point_x;
                     max_x_in = req_if.point_x;
                     min_y_in = req_if.point_y;
                     max_y_in = req_if.point_y;
                  end else begin
                     if (req_if.point_x < min_x_ff) min_x_in = req_if.point_x;
                     if (req_if.point_x > max_x_ff) max_x_in = req_if.point_x;
                     if (req_if.point_y < min_y_ff) min_y_in = req_if.point_y;
                     if (req_if.point_y > max_y_ff) max_y_in = req_if.point_y;
                  end
               end
            end
            ACT_TEST: begin
            end
            default: begin
            end
         endcase
      end else if (chain_done) begin
         inside_in = ~outside_fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         min_x_ff <= '0;
         max_x_ff <= '0;
         min_y_ff <= '0;
         max_y_ff <= '0;
         inside_ff <= 1'b0;
         full_ff <= 1'b0;
         launch_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         min_x_ff <= min_x_in;
         max_x_ff <= max_x_in;
         min_y_ff <= min_y_in;
         max_y_ff <= max_y_in;
         inside_ff <= inside_in;
         full_ff <= full_in;
         launch_ff <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         launch_x_ff <= req_if.point_x;
         launch_y_ff <= req_if.point_y;
      end
   end

   // Head of the cell chain.
   assign tok_flags[0] = '{valid: launch_ff, outside: 1'b0, prod_valid: 1'b0};
   assign tok_x[0] = launch_x_ff;
   assign tok_y[0] = launch_y_ff;
   assign tok_prod_a[0] = '0;
   assign tok_prod_b[0] = '0;

   for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
      cph_cell #(
         .INDEX      (k),
         .COUNT_BITS (COUNT_BITS),
         .COORD_BITS (COORD_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .wr_en     (vert_we),
         .count     (count_ff),
         .new_x     (req_if.point_x),
         .new_y     (req_if.point_y),
         .first_x   (vx[0]),
         .first_y   (vy[0]),
         .next_x    (vx[(k + 1) % MAX_VERTICES]),
         .next_y    (vy[(k + 1) % MAX_VERTICES]),
         .vert_x    (vx[k]),
         .vert_y    (vy[k]),
         .up_flags  (tok_flags[k]),
         .up_x      (tok_x[k]),
         .up_y      (tok_y[k]),
         .up_prod_a (tok_prod_a[k]),
         .up_prod_b (tok_prod_b[k]),
         .dn_flags  (tok_flags[k+1]),
         .dn_x      (tok_x[k+1]),
         .dn_y      (tok_y[k+1]),
         .dn_prod_a (tok_prod_a[k+1]),
         .dn_prod_b (tok_prod_b[k+1])
      );
   end

   // The midpoint is the floor of half the sum, so an arithmetic shift of the wide sum.
   always_comb begin
      sum_x = {min_x_ff[COORD_BITS-1], min_x_ff} + {max_x_ff[COORD_BITS-1], max_x_ff};
      sum_y = {min_y_ff[COORD_BITS-1], min_y_ff} + {max_y_ff[COORD_BITS-1], max_y_ff};
      span_x = max_x_ff - min_x_ff;
      span_y = max_y_ff - min_y_ff;
      res_data = {inside_ff, full_ff, sum_x[COORD_BITS:1], sum_y[COORD_BITS:1], span_x, span_y};
   end

   // Output register with one holding entry behind it.
   always_comb begin
      out_free = ~rsp_valid_ff | rsp_if.ready;
      rsp_valid_in = rsp_valid_ff & ~rsp_if.ready;
      pend_valid_in = pend_valid_ff;
      load_out_pend = 1'b0;
      load_out_res = 1'b0;
      load_pend = 1'b0;
      if (out_free && pend_valid_ff) begin
         rsp_valid_in = 1'b1;
         pend_valid_in = 1'b0;
         load_out_pend = 1'b1;
      end else if (finish && out_free) begin
         rsp_valid_in = 1'b1;
         load_out_res = 1'b1;
      end else if (finish) begin
         pend_valid_in = 1'b1;
         load_pend = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out_pend) begin
         rsp_data_ff <= pend_data_ff;
      end else if (load_out_res) begin
         rsp_data_ff <= res_data;
      end
      if (load_pend) begin
         pend_data_ff <= res_data;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.inside_res = rsp_data_ff[RES_BITS-1];
   assign rsp_if.store_full = rsp_data_ff[RES_BITS-2];
   assign rsp_if.mid_x = rsp_data_ff[4*COORD_BITS-1:3*COORD_BITS];
   assign rsp_if.mid_y = rsp_data_ff[3*COORD_BITS-1:2*COORD_BITS];
   assign rsp_if.span_x = rsp_data_ff[2*COORD_BITS-1:COORD_BITS];
   assign rsp_if.span_y = rsp_data_ff[COORD_BITS-1:0];

endmodule

// ===== sv/cph_cell.sv =====
// One vertex cell of the edge chain: holds a vertex and tests its edge against a passing point.
module cph_cell #(
   parameter int INDEX = 0,
   parameter int COUNT_BITS = 7,
   parameter int COORD_BITS = cph_pkg::COORD_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [COUNT_BITS-1:0]            count,
   input  logic signed [COORD_BITS-1:0]     new_x,
   input  logic signed [COORD_BITS-1:0]     new_y,
   input  logic signed [COORD_BITS-1:0]     first_x,
   input  logic signed [COORD_BITS-1:0]     first_y,
   input  logic signed [COORD_BITS-1:0]     next_x,
   input  logic signed [COORD_BITS-1:0]     next_y,
   output logic signed [COORD_BITS-1:0]     vert_x,
   output logic signed [COORD_BITS-1:0]     vert_y,
   input  cph_pkg::tok_flags_type           up_flags,
   input  logic signed [COORD_BITS-1:0]     up_x,
   input  logic signed [COORD_BITS-1:0]     up_y,
   input  logic signed [2*COORD_BITS+1:0]   up_prod_a,
   input  logic signed [2*COORD_BITS+1:0]   up_prod_b,
   output cph_pkg::tok_flags_type           dn_flags,
   output logic signed [COORD_BITS-1:0]     dn_x,
   output logic signed [COORD_BITS-1:0]     dn_y,
   output logic signed [2*COORD_BITS+1:0]   dn_prod_a,
   output logic signed [2*COORD_BITS+1:0]   dn_prod_b
);
   import cph_pkg::*;

   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = 2 * DIFF_BITS;
   localparam logic [COUNT_BITS-1:0] IDX = COUNT_BITS'(INDEX);

   logic signed [COORD_BITS-1:0] vx_ff, vy_ff;
   logic signed [COORD_BITS-1:0] end_x, end_y;
   logic signed [DIFF_BITS-1:0]  ex, ey, qx, qy;
   logic                         active, last;
   tok_flags_type                flags_ff, flags_in;
   logic signed [COORD_BITS-1:0] x_ff, y_ff;
   logic signed [PROD_BITS-1:0]  prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;

   always_ff @(posedge clock) begin
      if (wr_en && (count == IDX)) begin
         vx_ff <= new_x;
         vy_ff <= new_y;
      end
   end

   assign vert_x = vx_ff;
   assign vert_y = vy_ff;

   // The last stored vertex closes the polygon back to the first one.
   always_comb begin
      active = IDX < count;
      last = (IDX + COUNT_BITS'(1)) == count;
      end_x = last ? first_x : next_x;
      end_y = last ? first_y : next_y;
      ex = {end_x[COORD_BITS-1], end_x} - {vx_ff[COORD_BITS-1], vx_ff};
      ey = {end_y[COORD_BITS-1], end_y} - {vy_ff[COORD_BITS-1], vy_ff};
      qx = {up_x[COORD_BITS-1], up_x} - {vx_ff[COORD_BITS-1], vx_ff};
      qy = {up_y[COORD_BITS-1], up_y} - {vy_ff[COORD_BITS-1], vy_ff};
      prod_a_in = ex * qy;
      prod_b_in = ey * qx;
      flags_in.valid = up_flags.valid;
      flags_in.outside = up_flags.outside |
                         (up_flags.prod_valid & (up_prod_a > up_prod_b));
      flags_in.prod_valid = up_flags.valid & active;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= up_x;
      y_ff <= up_y;
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
   end

   assign dn_flags = flags_ff;
   assign dn_x = x_ff;
   assign dn_y = y_ff;
   assign dn_prod_a = prod_a_ff;
   assign dn_prod_b = prod_b_ff;

endmodule
